// ----- rtl/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE) + 1;
   localparam int TICK_W        = 16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP_TICKS = 2'd2;

   localparam logic [TICK_W-1:0] TICKS_RESET = 16'd4;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_type;

   typedef enum logic [13:0] {
      PH_IDLE    = 14'b00000000000001,
      PH_ST_A    = 14'b00000000000010,
      PH_ST_B    = 14'b00000000000100,
      PH_ST_C    = 14'b00000000001000,
      PH_W_LOW   = 14'b00000000010000,
      PH_W_HIGH  = 14'b00000000100000,
      PH_WA_LOW  = 14'b00000001000000,
      PH_WA_HIGH = 14'b00000010000000,
      PH_R_LOW   = 14'b00000100000000,
      PH_R_HIGH  = 14'b00001000000000,
      PH_RA_LOW  = 14'b00010000000000,
      PH_RA_HIGH = 14'b00100000000000,
      PH_SP_A    = 14'b01000000000000,
      PH_SP_B    = 14'b10000000000000
   } phase_type;

   // Line drive bits: bit 0 pulls SCL low, bit 1 pulls SDA low.
   localparam logic [1:0] DRV_NONE = 2'b00;
   localparam logic [1:0] DRV_SCL  = 2'b01;
   localparam logic [1:0] DRV_SDA  = 2'b10;
   localparam logic [1:0] DRV_BOTH = 2'b11;

   typedef struct packed {
      logic [TICK_W-1:0] low_ticks;
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] setup_ticks;
   } timing_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack;
   } result_type;

endpackage

// ----- rtl/i2cm_core.sv -----
`timescale 1ns / 1ps

module i2cm_core
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  timing_type timing,
   input  logic       tick_en,
   input  logic [2:0] req_type,
   input  logic [7:0] tx_byte,
   input  logic       final_byte,
   input  logic       sda_in,
   output result_type result
);

   phase_type              phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic [1:0]             drive_ff, drive_in;
   logic                   ack_ff, ack_in;
   logic                   nack_ff, nack_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   done;
   logic [TICK_W:0]        tick_next;
   logic [TICK_W-1:0]      phase_len;
   logic [7:0]             shift_wr;
   logic [7:0]             shift_rd;
   logic [BIT_IDX_W-1:0]   bit_next;
   logic                   byte_more;

   always_comb begin
      unique case (phase_ff)
         PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B: begin
            phase_len = timing.setup_ticks;
         end
         PH_ST_A, PH_W_LOW, PH_WA_LOW, PH_R_LOW, PH_RA_LOW: begin
            phase_len = timing.low_ticks;
         end
         default: begin
            phase_len = timing.high_ticks;
         end
      endcase
   end

   assign tick_next = {1'b0, tick_ff} + {{TICK_W{1'b0}}, 1'b1};
   assign shift_wr  = {shift_ff[6:0], 1'b0};
   assign shift_rd  = {shift_ff[6:0], sda_in};
   assign bit_next  = bit_ff + {{(BIT_IDX_W-1){1'b0}}, 1'b1};
   assign byte_more = bit_next < BIT_IDX_W'(BITS_PER_BYTE);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      drive_in = drive_ff;
      ack_in   = ack_ff;
      nack_in  = nack_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         tick_in = '0;
         priority case (req_type)
            CMD_START: begin
               phase_in = PH_ST_A;
               drive_in = DRV_SCL | (drive_ff & DRV_SDA);
            end
            CMD_WRITE: begin
               shift_in = tx_byte;
               bit_in   = '0;
               phase_in = PH_W_LOW;
               drive_in = tx_byte[7] ? DRV_SCL : DRV_BOTH;
            end
            CMD_READ: begin
               shift_in = '0;
               bit_in   = '0;
               ack_in   = final_byte;
               phase_in = PH_R_LOW;
               drive_in = DRV_SCL;
            end
            CMD_STOP: begin
               phase_in = PH_SP_A;
               drive_in = DRV_BOTH;
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end else if (tick_next < {1'b0, phase_len}) begin
         tick_in = tick_next[TICK_W-1:0];
      end else begin
         tick_in = '0;
         unique case (phase_ff)
            PH_ST_A: begin
               phase_in = PH_ST_B;
               drive_in = DRV_NONE;
            end
            PH_ST_B: begin
               phase_in = PH_ST_C;
               drive_in = DRV_SDA;
            end
            PH_ST_C: begin
               phase_in = PH_IDLE;
               drive_in = DRV_BOTH;
               done     = 1'b1;
            end
            PH_W_LOW: begin
               phase_in = PH_W_HIGH;
               drive_in = drive_ff & DRV_SDA;
            end
            PH_W_HIGH: begin
               shift_in = shift_wr;
               bit_in   = bit_next;
               if (byte_more) begin
                  phase_in = PH_W_LOW;
                  drive_in = shift_wr[7] ? DRV_SCL : DRV_BOTH;
               end else begin
                  phase_in = PH_WA_LOW;
                  drive_in = DRV_SCL;
               end
            end
            PH_WA_LOW: begin
               phase_in = PH_WA_HIGH;
               drive_in = DRV_NONE;
            end
            PH_WA_HIGH: begin
               nack_in  = sda_in;
               phase_in = PH_IDLE;
               drive_in = DRV_SCL;
               done     = 1'b1;
            end
            PH_R_LOW: begin
               phase_in = PH_R_HIGH;
               drive_in = DRV_NONE;
            end
            PH_R_HIGH: begin
               shift_in = shift_rd;
               bit_in   = bit_next;
               if (byte_more) begin
                  phase_in = PH_R_LOW;
                  drive_in = DRV_SCL;
               end else begin
                  phase_in = PH_RA_LOW;
                  drive_in = ack_ff ? DRV_SCL : DRV_BOTH;
               end
            end
            PH_RA_LOW: begin
               phase_in = PH_RA_HIGH;
               drive_in = drive_ff & DRV_SDA;
            end
            PH_RA_HIGH: begin
               rx_in    = shift_ff;
               phase_in = PH_IDLE;
               drive_in = DRV_SCL;
               done     = 1'b1;
            end
            PH_SP_A: begin
               phase_in = PH_SP_B;
               drive_in = DRV_SDA;
            end
            PH_SP_B: begin
               phase_in = PH_IDLE;
               drive_in = DRV_NONE;
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         drive_ff <= DRV_NONE;
         ack_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         rx_ff    <= '0;
      end else if (tick_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         drive_ff <= drive_in;
         ack_ff   <= ack_in;
         nack_ff  <= nack_in;
         rx_ff    <= rx_in;
      end
   end

   assign result.scl_low  = drive_in[0];
   assign result.sda_low  = drive_in[1];
   assign result.busy_res = phase_in != PH_IDLE;
   assign result.done_res = done;
   assign result.rx_byte  = rx_in;
   assign result.nack     = nack_in;

endmodule

// ----- rtl/i2cm_out_queue.sv -----
`timescale 1ns / 1ps

module i2cm_out_queue
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign ready     = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot0_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      unique case (count_ff)
         2'd0: begin
            if (push) begin
               slot0_in = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               slot0_in = push_data;
            end else if (push) begin
               slot1_in = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (pop) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ----- rtl/i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps

// Open-drain I2C master bit engine. Each transfer on the req_ channel is one timing tick
// and produces exactly one transfer on the rsp_ channel carrying the SCL and SDA
// drive-low levels after that tick, busy, done, the last received byte and the NACK
// flag. A command (start, write byte, read byte, stop) in req_tuser is taken only when
// the engine is idle and is ignored otherwise. The engine takes one tick per clock while
// req_tready is high; results leave through a two-entry output queue, and req_tready
// drops only when two are waiting. Phase lengths come from the low, high and setup tick
// registers on the csr_ port, which should be written only while the engine is idle.
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [7:0] tx_byte, [8] sda_in, [15:9] zero
   input  logic [15:0]          req_tdata,
   // [2:0] req_type
   input  logic [2:0]           req_tuser,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [0] scl_low, [1] sda_low, [2] busy_res, [10:3] rx_byte, [11] nack, [15:12] zero
   output logic [15:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   timing_type timing_ff;
   result_type result;
   result_type head;
   logic       tick_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.low_ticks   <= TICKS_RESET;
         timing_ff.high_ticks  <= TICKS_RESET;
         timing_ff.setup_ticks <= TICKS_RESET;
      end else if (csr_we) begin
         priority case (csr_index)
            CSR_LOW_TICKS:   timing_ff.low_ticks   <= csr_wdata;
            CSR_HIGH_TICKS:  timing_ff.high_ticks  <= csr_wdata;
            CSR_SETUP_TICKS: timing_ff.setup_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign tick_en = req_tvalid && req_tready;

   i2cm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .timing     (timing_ff),
      .tick_en    (tick_en),
      .req_type   (req_tuser),
      .tx_byte    (req_tdata[7:0]),
      .final_byte (req_tlast),
      .sda_in     (req_tdata[8]),
      .result     (result)
   );

   i2cm_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tick_en),
      .push_data (result),
      .ready     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {4'b0000, head.nack, head.rx_byte, head.busy_res,
                       head.sda_low, head.scl_low};
   assign rsp_tlast = head.done_res;

endmodule

// ----- dv/i2c_master_bit_engine_check.sv -----
`timescale 1ns / 1ps

module i2c_master_bit_engine_check
   import i2cm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [15:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   input  logic                 req_tlast,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [15:0]          rsp_tdata,
   input  logic                 rsp_tlast,
   output int                   fail_count,
   output int                   pending,
   output logic                 engine_idle
);

   timing_type           timing;
   phase_type            phase;
   logic [16:0]          tick_count;
   logic [BIT_IDX_W-1:0] bit_index;
   logic [7:0]           shift_byte;
   logic [7:0]           rx_hold;
   logic [1:0]           line_drive;
   logic                 ack_mode;
   logic                 nack_flag;
   result_type           expected_lines[$];

   initial begin
      fail_count = 0;
      pending = 0;
      engine_idle = 1'b1;
   end

   function automatic void enter_phase(phase_type next, logic [1:0] drive);
      phase = next;
      line_drive = drive;
      tick_count = '0;
   endfunction

   function automatic logic [1:0] bit_drive();
      return shift_byte[7] ? DRV_SCL : DRV_BOTH;
   endfunction

   function automatic logic [16:0] phase_length(phase_type p);
      case (p)
         PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B: return {1'b0, timing.setup_ticks};
         PH_ST_A, PH_W_LOW, PH_WA_LOW, PH_R_LOW, PH_RA_LOW: return {1'b0, timing.low_ticks};
         default: return {1'b0, timing.high_ticks};
      endcase
   endfunction

   function automatic logic next_phase(logic sda);
      logic finished;
      finished = 1'b0;
      case (phase)
         PH_ST_A: enter_phase(PH_ST_B, DRV_NONE);
         PH_ST_B: enter_phase(PH_ST_C, DRV_SDA);
         PH_ST_C: begin
            enter_phase(PH_IDLE, DRV_BOTH);
            finished = 1'b1;
         end
         PH_W_LOW: enter_phase(PH_W_HIGH, line_drive & DRV_SDA);
         PH_W_HIGH: begin
            shift_byte = {shift_byte[6:0], 1'b0};
            bit_index = bit_index + 1'b1;
            if (bit_index < BITS_PER_BYTE) begin
               enter_phase(PH_W_LOW, bit_drive());
            end else begin
               enter_phase(PH_WA_LOW, DRV_SCL);
            end
         end
         PH_WA_LOW: enter_phase(PH_WA_HIGH, DRV_NONE);
         PH_WA_HIGH: begin
            nack_flag = sda;
            enter_phase(PH_IDLE, DRV_SCL);
            finished = 1'b1;
         end
         PH_R_LOW: enter_phase(PH_R_HIGH, DRV_NONE);
         PH_R_HIGH: begin
            shift_byte = {shift_byte[6:0], sda};
            bit_index = bit_index + 1'b1;
            if (bit_index < BITS_PER_BYTE) begin
               enter_phase(PH_R_LOW, DRV_SCL);
            end else begin
               enter_phase(PH_RA_LOW, ack_mode ? DRV_SCL : DRV_BOTH);
            end
         end
         PH_RA_LOW: enter_phase(PH_RA_HIGH, line_drive & DRV_SDA);
         PH_RA_HIGH: begin
            rx_hold = shift_byte;
            enter_phase(PH_IDLE, DRV_SCL);
            finished = 1'b1;
         end
         PH_SP_A: enter_phase(PH_SP_B, DRV_SDA);
         PH_SP_B: begin
            enter_phase(PH_IDLE, DRV_NONE);
            finished = 1'b1;
         end
         default: enter_phase(PH_IDLE, line_drive);
      endcase
      return finished;
   endfunction

   function automatic result_type step_bus(logic [2:0] code, logic [7:0] tx, logic fin,
                                           logic sda);
      result_type lines;
      logic       finished;
      finished = 1'b0;
      if (phase == PH_IDLE) begin
         case (code)
            CMD_START: enter_phase(PH_ST_A, DRV_SCL | (line_drive & DRV_SDA));
            CMD_WRITE: begin
               shift_byte = tx;
               bit_index = '0;
               enter_phase(PH_W_LOW, bit_drive());
            end
            CMD_READ: begin
               shift_byte = '0;
               bit_index = '0;
               ack_mode = fin;
               enter_phase(PH_R_LOW, DRV_SCL);
            end
            CMD_STOP: enter_phase(PH_SP_A, DRV_BOTH);
            default: ;
         endcase
      end else begin
         tick_count = tick_count + 17'd1;
         if (tick_count >= phase_length(phase)) begin
            finished = next_phase(sda);
         end
      end
      lines.scl_low = line_drive[0];
      lines.sda_low = line_drive[1];
      lines.busy_res = (phase != PH_IDLE);
      lines.done_res = finished;
      lines.rx_byte = rx_hold;
      lines.nack = nack_flag;
      return lines;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         timing = '{low_ticks: TICKS_RESET, high_ticks: TICKS_RESET, setup_ticks: TICKS_RESET};
         phase = PH_IDLE;
         tick_count = '0;
         bit_index = '0;
         shift_byte = '0;
         rx_hold = '0;
         line_drive = DRV_NONE;
         ack_mode = 1'b0;
         nack_flag = 1'b0;
         expected_lines.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lines.size() == 0) begin
               $error("Result transfer arrived with no expectation waiting.");
               fail_count++;
            end else begin
               want = expected_lines.pop_front();
               check_field("scl_low", want.scl_low, rsp_tdata[0]);
               check_field("sda_low", want.sda_low, rsp_tdata[1]);
               check_field("busy_res", want.busy_res, rsp_tdata[2]);
               check_field("done_res", want.done_res, rsp_tlast);
               check_field("rx_byte", want.rx_byte, rsp_tdata[10:3]);
               check_field("nack", want.nack, rsp_tdata[11]);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_TICKS:   timing.low_ticks = csr_wdata;
               CSR_HIGH_TICKS:  timing.high_ticks = csr_wdata;
               CSR_SETUP_TICKS: timing.setup_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_lines.push_back(step_bus(req_tuser, req_tdata[7:0], req_tlast,
                                              req_tdata[8]));
         end
      end
      pending = expected_lines.size();
      engine_idle = (phase == PH_IDLE);
   end

endmodule

// ----- dv/i2c_master_bit_engine_test.sv -----
`timescale 1ns / 1ps

module i2c_master_bit_engine_test;
   import i2cm_pkg::*;

   localparam int         CYCLE_LIMIT = 2_000_000;
   localparam int         LONG_HOLD = 400;
   localparam logic [2:0] CODE_MAX = 3'b111;

   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_level_type;
   typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LOW_TICKS;
   logic [TICK_W-1:0]    csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic [2:0]           req_tuser = CMD_TICK;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tlast;
   int                   fail_count;
   int                   pending;
   logic                 engine_idle;
   logic                 hold_pending = 1'b0;
   int                   cycles = 0;

   always #5 clock = ~clock;

   i2c_master_bit_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   i2c_master_bit_engine_check i_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .pending     (pending),
      .engine_idle (engine_idle)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic pick_sda(sda_level_type level);
      case (level)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic send_tick(logic [2:0] code, logic [7:0] tx, logic fin, logic sda);
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {7'd0, sda, tx};
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain(sda_level_type level);
      while (!engine_idle) begin
         send_tick(CMD_TICK, 8'($urandom), 1'($urandom), pick_sda(level));
      end
   endtask

   task automatic command(cmd_type code, logic [7:0] tx, logic fin, sda_level_type level);
      send_tick(code, tx, fin, pick_sda(level));
      drain(level);
   endtask

   task automatic quiesce();
      drain(SDA_RANDOM);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_timing(logic [TICK_W-1:0] low, logic [TICK_W-1:0] high,
                             logic [TICK_W-1:0] setup);
      csr_we <= 1'b1;
      csr_index <= CSR_LOW_TICKS;
      csr_wdata <= low;
      @(negedge clock);
      csr_index <= CSR_HIGH_TICKS;
      csr_wdata <= high;
      @(negedge clock);
      csr_index <= CSR_SETUP_TICKS;
      csr_wdata <= setup;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_ticks(int count);
      int         sent;
      int         burst;
      int         gap;
      int         roll;
      logic [2:0] code;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
         repeat (burst) begin
            roll = $urandom_range(0, 99);
            code = CMD_TICK;
            if (engine_idle) begin
               if (roll < 22) begin
                  code = CMD_WRITE;
               end else if (roll < 42) begin
                  code = CMD_READ;
               end else if (roll < 56) begin
                  code = CMD_START;
               end else if (roll < 66) begin
                  code = CMD_STOP;
               end else if (roll < 74) begin
                  code = 3'($urandom_range(int'(CMD_STOP) + 1, int'(CODE_MAX)));
               end
            end else if (roll < 12) begin
               code = 3'($urandom_range(int'(CMD_START), int'(CODE_MAX)));
            end
            send_tick(code, 8'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             hold_left;
      logic [7:0]     pattern;
      mode = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      pattern = 8'hFF;
      forever begin
         @(negedge clock);
         if (hold_pending && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(16, 96);
               pattern = 8'($urandom) | 8'h01;
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_PATTERN: begin
                  rsp_tready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      int code;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing: plain ticks, spare codes, then each command and the corner cases.
      send_tick(CMD_TICK, 8'h00, 1'b0, 1'b0);
      send_tick(CMD_TICK, 8'hFF, 1'b1, 1'b1);
      for (code = int'(CMD_STOP) + 1; code <= int'(CODE_MAX); code++) begin
         send_tick(3'(code), 8'($urandom), 1'($urandom), 1'($urandom));
      end
      command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      command(CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH);
      command(CMD_WRITE, 8'h00, 1'b1, SDA_LOW);
      command(CMD_READ, 8'hFF, 1'b0, SDA_HIGH);
      command(CMD_READ, 8'h00, 1'b1, SDA_LOW);
      command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      send_tick(CMD_START, 8'h00, 1'b0, 1'b0);
      send_tick(CMD_WRITE, 8'h3C, 1'b0, 1'b1);
      send_tick(CMD_STOP, 8'hC3, 1'b1, 1'b0);
      drain(SDA_RANDOM);
      command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      command(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM);
      command(CMD_WRITE, 8'h96, 1'b0, SDA_RANDOM);
      quiesce();

      set_timing(16'd1, 16'd1, 16'd1);
      hold_pending = 1'b1;
      random_ticks(90);
      quiesce();

      set_timing(16'd0, 16'd2, 16'd0);
      random_ticks(50);
      quiesce();

      set_timing(16'd3, 16'd1, 16'd2);
      random_ticks(35);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      random_ticks(35);
      quiesce();

      set_timing(16'd40, 16'd40, 16'd1);
      command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      quiesce();

      set_timing(16'd1, 16'd1, 16'd30);
      command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      quiesce();

      set_timing(16'd2, 16'd5, 16'd1);
      random_ticks(60);
      quiesce();

      set_timing(TICKS_RESET, TICKS_RESET, TICKS_RESET);
      random_ticks(40);
      quiesce();
      repeat (20) @(negedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
